@@ rtl/ptfr_pkg.sv @@
`timescale 1ns / 1ps

package ptfr_pkg;

  localparam int OFFSET_BITS = 11;
  localparam int VIRT_PAGES  = 32;
  localparam int PHYS_FRAMES = 8;

  localparam int VA_W    = 16;
  localparam int PA_W    = 14;
  localparam int EVP_W   = 5;
  localparam int CNT_W   = 16;
  localparam int PAGE_W  = $clog2(VIRT_PAGES);
  localparam int FRAME_W = $clog2(PHYS_FRAMES);

  typedef logic [PAGE_W-1:0]      page_t;
  typedef logic [FRAME_W-1:0]     frame_t;
  typedef logic [OFFSET_BITS-1:0] offset_t;

  typedef enum logic {
    ST_IDLE,
    ST_LOOK
  } state_t;

endpackage

@@ rtl/ptfr_ram.sv @@
`timescale 1ns / 1ps

module ptfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/page_translate_fifo_replace_unit.sv @@
`timescale 1ns / 1ps
// A word accepted in ST_IDLE reads the frame and owner RAMs into their registered outputs; in
// ST_LOOK, once the output is free, it is translated, written back and registered on the output.
// No new word is accepted while one is in ST_LOOK; a new word is accepted while a result waits, and a
// waiting result holds the translation until the output frees.
// Reset clears present and used bits, the replacement pointer and the fault count;
// RAM contents are not cleared and are read only after being written.

module page_translate_fifo_replace_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [ptfr_pkg::VA_W-1:0]            virt_addr,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [ptfr_pkg::PA_W-1:0]            phys_addr,
  output logic                                 page_fault,
  output logic                                 evicted_valid,
  output logic [ptfr_pkg::EVP_W-1:0]           evicted_page,
  output logic [ptfr_pkg::CNT_W-1:0]           fault_total
);

  ptfr_pkg::state_t  state, state_next;
  ptfr_pkg::page_t   page_q;
  ptfr_pkg::offset_t offset_q;
  ptfr_pkg::frame_t  next_frame, next_frame_next;
  logic [ptfr_pkg::VIRT_PAGES-1:0]  page_present, page_present_next;
  logic [ptfr_pkg::PHYS_FRAMES-1:0] frame_used, frame_used_next;
  logic [ptfr_pkg::CNT_W-1:0]       fault_count, fault_count_next;

  ptfr_pkg::frame_t  pf_rdata;
  ptfr_pkg::page_t   fo_rdata;

  logic              in_accept;
  logic              out_free;
  logic              commit;
  logic              hit;
  logic              evict;
  ptfr_pkg::frame_t  frame;
  ptfr_pkg::page_t   in_page;

  assign in_page   = ptfr_pkg::PAGE_W'((virt_addr >> ptfr_pkg::OFFSET_BITS)
                                       % ptfr_pkg::VIRT_PAGES);
  assign in_stall  = (state != ptfr_pkg::ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign commit    = (state == ptfr_pkg::ST_LOOK) && out_free;

  assign hit   = page_present[page_q];
  assign frame = hit ? pf_rdata : next_frame;
  assign evict = !hit && frame_used[next_frame];

  ptfr_ram #(
    .WIDTH(ptfr_pkg::FRAME_W),
    .DEPTH(ptfr_pkg::VIRT_PAGES)
  ) u_page_frame (
    .clk   (clk),
    .we    (commit && !hit),
    .waddr (page_q),
    .wdata (next_frame),
    .re    (in_accept),
    .raddr (in_page),
    .rdata (pf_rdata)
  );

  ptfr_ram #(
    .WIDTH(ptfr_pkg::PAGE_W),
    .DEPTH(ptfr_pkg::PHYS_FRAMES)
  ) u_frame_owner (
    .clk   (clk),
    .we    (commit && !hit),
    .waddr (next_frame),
    .wdata (page_q),
    .re    (in_accept),
    .raddr (next_frame),
    .rdata (fo_rdata)
  );

  always_comb begin
    state_next        = state;
    page_present_next = page_present;
    frame_used_next   = frame_used;
    next_frame_next   = next_frame;
    fault_count_next  = fault_count;
    case (state)
      ptfr_pkg::ST_IDLE: begin
        if (in_accept) begin
          state_next = ptfr_pkg::ST_LOOK;
        end
      end
      ptfr_pkg::ST_LOOK: begin
        if (commit) begin
          state_next = ptfr_pkg::ST_IDLE;
          if (!hit) begin
            if (evict) begin
              page_present_next[fo_rdata] = 1'b0;
            end
            page_present_next[page_q]  = 1'b1;
            frame_used_next[next_frame] = 1'b1;
            if (next_frame == ptfr_pkg::FRAME_W'(ptfr_pkg::PHYS_FRAMES - 1)) begin
              next_frame_next = '0;
            end else begin
              next_frame_next = next_frame + 1'b1;
            end
            if (fault_count != '1) begin
              fault_count_next = fault_count + 1'b1;
            end
          end
        end
      end
      default: begin
        state_next = ptfr_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ptfr_pkg::ST_IDLE;
      page_present <= '0;
      frame_used   <= '0;
      next_frame   <= '0;
      fault_count  <= '0;
    end else begin
      state        <= state_next;
      page_present <= page_present_next;
      frame_used   <= frame_used_next;
      next_frame   <= next_frame_next;
      fault_count  <= fault_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      page_q   <= in_page;
      offset_q <= ptfr_pkg::OFFSET_BITS'(virt_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      phys_addr     <= ptfr_pkg::PA_W'({frame, offset_q});
      page_fault    <= !hit;
      evicted_valid <= evict;
      evicted_page  <= evict ? ptfr_pkg::EVP_W'(fo_rdata) : '0;
      fault_total   <= fault_count_next;
    end
  end

  a_evict_needs_fault: assert property (@(posedge clk) disable iff (rst)
    out_valid && evicted_valid |-> page_fault)
    else $error("eviction reported without a fault");

  a_present_matches_used: assert property (@(posedge clk) disable iff (rst)
    $countones(page_present) == $countones(frame_used))
    else $error("resident page count differs from used frame count");

  a_count_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> fault_count >= $past(fault_count))
    else $error("fault count decreased");

  a_hit_keeps_tables: assert property (@(posedge clk) disable iff (rst)
    commit && hit |=> $stable(page_present) && $stable(next_frame))
    else $error("tables changed on a hit");

endmodule
